FILE: design/normal_inverse_cdf_approx_defines.svh
// assertion macros for the inverse normal cdf block
`ifndef NORMAL_INVERSE_CDF_APPROX_DEFINES_SVH
`define NORMAL_INVERSE_CDF_APPROX_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define NICA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nica assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define NICA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nica assertion failed");

`endif

FILE: design/nica_pkg.sv
// shared widths and constants of the inverse normal cdf block
package nica_pkg;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 20;
    localparam int P_W       = 32;
    localparam int K_W       = 5;
    localparam int M_W       = 31;
    localparam int LOG_ITERS = 28;
    localparam int L_W       = 34;
    localparam int PROD_W    = 65;
    localparam int ARG_W     = 34;
    localparam int N_W       = 46;
    localparam int T_W       = 23;
    localparam int Q_W       = 22;
    localparam int A1_W      = 39;
    localparam int PA1_W     = 62;
    localparam int A2_W      = 43;
    localparam int PA2_W     = 66;
    localparam int DEN_W     = 47;
    localparam int B1_W      = 41;
    localparam int PB1_W     = 64;
    localparam int NUM_W     = 45;
    localparam int REM_W     = 65;
    localparam int DIV_W     = 70;
    localparam int MAG_W     = 28;

    localparam logic [P_W-1:0]  P_MIN       = 32'd4295;
    localparam logic [30:0]     TWO_LN2_Q30 = 31'd1488522236;

    // coefficients scaled by 10^6, the scale cancels in the quotient
    localparam logic [63:0] C_N0 = 64'd2515517;
    localparam logic [63:0] C_N1 = 64'd802853;
    localparam logic [63:0] C_N2 = 64'd10328;
    localparam logic [63:0] C_D0 = 64'd1000000;
    localparam logic [63:0] C_D1 = 64'd1432788;
    localparam logic [63:0] C_D2 = 64'd189269;
    localparam logic [63:0] C_D3 = 64'd1308;
endpackage

FILE: design/nica_in_if.sv
// input channel carrying one uniform fraction per item
interface nica_in_if;
    logic                        valid;
    logic                        ready;
    logic [nica_pkg::IN_W-1:0]   uniform_fraction;

    modport source (output valid, output uniform_fraction, input ready);
    modport sink   (input valid, input uniform_fraction, output ready);
endinterface

FILE: design/nica_out_if.sv
// output channel carrying one normal deviate per item
interface nica_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [nica_pkg::OUT_W-1:0]  normal_value;

    modport source (output valid, output normal_value, input ready);
    modport sink   (input valid, input normal_value, output ready);
endinterface

FILE: design/normal_inverse_cdf_approx.sv
// inverse normal cdf (rational approximation) as a fully pipelined datapath
// Takes one 24-bit uniform fraction per cycle and returns one signed
// deviate with FRAC_BITS fraction bits per item, in order. Throughput is
// one item per clock as long as the sink takes results; the whole pipe
// holds when the output register is full and not taken, so nothing is
// dropped or repeated. The stages are:
// fold and clamp, leading-one search, normalize, 28 squaring stages for
// log2 (one 31x31 multiply each), scale by 2 ln 2, a 23-stage bit-serial
// square root, five stages of polynomial evaluation, a 22-stage restoring
// divider, then sign and rounding into the output register. No reset pass
// is needed: only the valid bits are cleared.
`include "normal_inverse_cdf_approx_defines.svh"

module normal_inverse_cdf_approx #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nica_in_if.sink     i_in,
    nica_out_if.source  o_out
);
    localparam int SQ_STEPS = nica_pkg::T_W;
    localparam int DV_STEPS = nica_pkg::Q_W;
    // s0, s1, log 0..28, L, product, sqrt 0..23, poly 5, div 0..22, f1, f2
    localparam int NST = 2 + (nica_pkg::LOG_ITERS + 1) + 2 + (SQ_STEPS + 1) + 5
                         + (DV_STEPS + 1) + 2;
    localparam int SH_R = (FRAC_BITS < 20) ? (20 - FRAC_BITS) : 0;
    localparam int SH_L = (FRAC_BITS > 20) ? (FRAC_BITS - 20) : 0;
    localparam logic [nica_pkg::MAG_W-1:0] RND = nica_pkg::MAG_W'((1 << SH_R) >> 1);
    localparam logic [nica_pkg::MAG_W-1:0] MAG_LIM = nica_pkg::MAG_W'(1 << 19);

    // global advance: the pipe moves unless a finished item sits unread
    logic w_ce;
    logic [NST-1:0] r_vld;

    assign w_ce        = !r_vld[NST-1] || o_out.ready;
    assign i_in.ready  = w_ce;
    assign o_out.valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    // stage 0: fold about one half and clamp the tail probability
    logic [nica_pkg::P_W-1:0] r_s0_p;
    logic                     r_s0_neg;
    logic [nica_pkg::IN_W-1:0] w_fold;
    logic [nica_pkg::P_W-1:0]  n_s0_p;

    always_comb begin
        w_fold = nica_pkg::IN_W'(25'h1000000 - {1'b0, i_in.uniform_fraction});
        if (!i_in.uniform_fraction[nica_pkg::IN_W-1]) begin
            n_s0_p = {i_in.uniform_fraction, 8'b0};
        end else begin
            n_s0_p = {w_fold, 8'b0};
        end
        if (n_s0_p < nica_pkg::P_MIN) begin
            n_s0_p = nica_pkg::P_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s0_p   <= n_s0_p;
            r_s0_neg <= !i_in.uniform_fraction[nica_pkg::IN_W-1];
        end
    end

    // stage 1: leading-one position
    logic [nica_pkg::P_W-1:0] r_s1_p;
    logic [nica_pkg::K_W-1:0] r_s1_k;
    logic                     r_s1_neg;
    logic [nica_pkg::K_W-1:0] n_s1_k;

    always_comb begin
        n_s1_k = '0;
        for (int i = 0; i < nica_pkg::P_W; i++) begin
            if (r_s0_p[i]) begin
                n_s1_k = nica_pkg::K_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s1_p   <= r_s0_p;
            r_s1_k   <= n_s1_k;
            r_s1_neg <= r_s0_neg;
        end
    end

    // log2 mantissa by repeated squaring, one fraction bit per stage
    logic [nica_pkg::M_W-1:0]       r_lm   [0:nica_pkg::LOG_ITERS];
    logic [nica_pkg::LOG_ITERS-1:0] r_lf   [0:nica_pkg::LOG_ITERS];
    logic [nica_pkg::K_W-1:0]       r_lk   [0:nica_pkg::LOG_ITERS];
    logic                           r_lneg [0:nica_pkg::LOG_ITERS];
    logic [nica_pkg::M_W-1:0]       n_lm0;

    always_comb begin
        if (r_s1_k == nica_pkg::K_W'(31)) begin
            n_lm0 = nica_pkg::M_W'(r_s1_p >> 1);
        end else begin
            n_lm0 = nica_pkg::M_W'(r_s1_p << (nica_pkg::K_W'(30) - r_s1_k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_lm[0]   <= n_lm0;
            r_lf[0]   <= '0;
            r_lk[0]   <= r_s1_k;
            r_lneg[0] <= r_s1_neg;
        end
    end

    for (genvar j = 0; j < nica_pkg::LOG_ITERS; j++) begin : g_log
        logic [2*nica_pkg::M_W-1:0]     w_sq;
        logic [nica_pkg::M_W:0]         w_s;
        logic [nica_pkg::M_W-1:0]       n_m;
        logic [nica_pkg::LOG_ITERS-1:0] n_f;

        always_comb begin
            w_sq = (2*nica_pkg::M_W)'(r_lm[j]) * (2*nica_pkg::M_W)'(r_lm[j]);
            w_s  = w_sq[2*nica_pkg::M_W-1:30];
            n_f  = r_lf[j];
            if (w_s[nica_pkg::M_W]) begin
                n_m = w_s[nica_pkg::M_W:1];
                n_f[nica_pkg::LOG_ITERS-1-j] = 1'b1;
            end else begin
                n_m = w_s[nica_pkg::M_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_lm[j+1]   <= n_m;
                r_lf[j+1]   <= n_f;
                r_lk[j+1]   <= r_lk[j];
                r_lneg[j+1] <= r_lneg[j];
            end
        end
    end

    // -log2 p in Q28, then times 2 ln 2
    logic [nica_pkg::L_W-1:0]    r_lq;
    logic                        r_lq_neg;
    logic [nica_pkg::PROD_W-1:0] r_prod;
    logic                        r_prod_neg;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_lq       <= (nica_pkg::L_W'(6'd32 - {1'b0, r_lk[nica_pkg::LOG_ITERS]}) << 28)
                          - nica_pkg::L_W'(r_lf[nica_pkg::LOG_ITERS]);
            r_lq_neg   <= r_lneg[nica_pkg::LOG_ITERS];
            r_prod     <= nica_pkg::PROD_W'(r_lq) * nica_pkg::PROD_W'(nica_pkg::TWO_LN2_Q30);
            r_prod_neg <= r_lq_neg;
        end
    end

    // square root, one root bit per stage from the top
    logic [nica_pkg::N_W-1:0] r_srem  [0:SQ_STEPS];
    logic [nica_pkg::T_W-1:0] r_sroot [0:SQ_STEPS];
    logic                     r_sneg  [0:SQ_STEPS];
    logic [nica_pkg::ARG_W-1:0] w_arg;

    assign w_arg = r_prod[63:30];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_srem[0]  <= {w_arg, 12'b0};
            r_sroot[0] <= '0;
            r_sneg[0]  <= r_prod_neg;
        end
    end

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        localparam int B = SQ_STEPS - 1 - i;
        logic [nica_pkg::N_W+1:0] w_term;
        logic [nica_pkg::N_W-1:0] n_rem;
        logic [nica_pkg::T_W-1:0] n_root;

        always_comb begin
            w_term = ((nica_pkg::N_W+2)'(r_sroot[i]) << (B + 1))
                     | ((nica_pkg::N_W+2)'(1) << (2 * B));
            n_rem  = r_srem[i];
            n_root = r_sroot[i];
            if ({2'b0, r_srem[i]} >= w_term) begin
                n_rem     = r_srem[i] - w_term[nica_pkg::N_W-1:0];
                n_root[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_srem[i+1]  <= n_rem;
                r_sroot[i+1] <= n_root;
                r_sneg[i+1]  <= r_sneg[i];
            end
        end
    end

    // rational polynomial terms by horner, products registered
    logic [nica_pkg::T_W-1:0]   w_t;
    logic [nica_pkg::T_W-1:0]   r_p1_t, r_p2_t, r_p3_t, r_p4_t, r_p5_t;
    logic                       r_p1_neg, r_p2_neg, r_p3_neg, r_p4_neg, r_p5_neg;
    logic [nica_pkg::A1_W-1:0]  r_a1;
    logic [nica_pkg::B1_W-1:0]  r_b1;
    logic [nica_pkg::PA1_W-1:0] r_pa1;
    logic [nica_pkg::PB1_W-1:0] r_pb1;
    logic [nica_pkg::A2_W-1:0]  r_a2;
    logic [nica_pkg::NUM_W-1:0] r_num3, r_num4, r_num5;
    logic [nica_pkg::PA2_W-1:0] r_pa2;
    logic [nica_pkg::DEN_W-1:0] r_den;

    assign w_t = r_sroot[SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a1     <= nica_pkg::A1_W'(64'(w_t) * nica_pkg::C_D3 + (nica_pkg::C_D2 << 20));
            r_b1     <= nica_pkg::B1_W'(64'(w_t) * nica_pkg::C_N2 + (nica_pkg::C_N1 << 20));
            r_p1_t   <= w_t;
            r_p1_neg <= r_sneg[SQ_STEPS];

            r_pa1    <= nica_pkg::PA1_W'(r_a1) * nica_pkg::PA1_W'(r_p1_t);
            r_pb1    <= nica_pkg::PB1_W'(r_b1) * nica_pkg::PB1_W'(r_p1_t);
            r_p2_t   <= r_p1_t;
            r_p2_neg <= r_p1_neg;

            r_a2     <= nica_pkg::A2_W'(r_pa1 >> 20) + nica_pkg::A2_W'(nica_pkg::C_D1 << 20);
            r_num3   <= nica_pkg::NUM_W'(r_pb1 >> 20) + nica_pkg::NUM_W'(nica_pkg::C_N0 << 20);
            r_p3_t   <= r_p2_t;
            r_p3_neg <= r_p2_neg;

            r_pa2    <= nica_pkg::PA2_W'(r_a2) * nica_pkg::PA2_W'(r_p3_t);
            r_num4   <= r_num3;
            r_p4_t   <= r_p3_t;
            r_p4_neg <= r_p3_neg;

            r_den    <= nica_pkg::DEN_W'(r_pa2 >> 20) + nica_pkg::DEN_W'(nica_pkg::C_D0 << 20);
            r_num5   <= r_num4;
            r_p5_t   <= r_p4_t;
            r_p5_neg <= r_p4_neg;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [nica_pkg::REM_W-1:0] r_drem [0:DV_STEPS];
    logic [nica_pkg::DEN_W-1:0] r_dden [0:DV_STEPS];
    logic [nica_pkg::Q_W-1:0]   r_dq   [0:DV_STEPS];
    logic [nica_pkg::T_W-1:0]   r_dt   [0:DV_STEPS];
    logic                       r_dneg [0:DV_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_drem[0] <= {r_num5, 20'b0};
            r_dden[0] <= r_den;
            r_dq[0]   <= '0;
            r_dt[0]   <= r_p5_t;
            r_dneg[0] <= r_p5_neg;
        end
    end

    for (genvar i = 0; i < DV_STEPS; i++) begin : g_div
        localparam int B = DV_STEPS - 1 - i;
        logic [nica_pkg::DIV_W-1:0] w_sub;
        logic [nica_pkg::REM_W-1:0] n_rem;
        logic [nica_pkg::Q_W-1:0]   n_q;

        always_comb begin
            w_sub = nica_pkg::DIV_W'(r_dden[i]) << B;
            n_rem = r_drem[i];
            n_q   = r_dq[i];
            if (nica_pkg::DIV_W'(r_drem[i]) >= w_sub) begin
                n_rem  = r_drem[i] - w_sub[nica_pkg::REM_W-1:0];
                n_q[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_drem[i+1] <= n_rem;
                r_dden[i+1] <= r_dden[i];
                r_dq[i+1]   <= n_q;
                r_dt[i+1]   <= r_dt[i];
                r_dneg[i+1] <= r_dneg[i];
            end
        end
    end

    // t - q, magnitude and final sign
    logic [nica_pkg::T_W:0]   w_diff;
    logic [nica_pkg::T_W-1:0] r_f1_mag;
    logic                     r_f1_sgn;

    assign w_diff = {1'b0, r_dt[DV_STEPS]} - {2'b0, r_dq[DV_STEPS]};

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_f1_mag <= w_diff[nica_pkg::T_W] ? nica_pkg::T_W'(-w_diff)
                                              : w_diff[nica_pkg::T_W-1:0];
            r_f1_sgn <= w_diff[nica_pkg::T_W] ^ r_dneg[DV_STEPS];
        end
    end

    // round half away from zero, saturate, output register
    logic [nica_pkg::MAG_W-1:0] w_mr;
    logic [nica_pkg::OUT_W-1:0] n_out;
    logic [nica_pkg::OUT_W-1:0] r_out;

    always_comb begin
        w_mr = ((nica_pkg::MAG_W'(r_f1_mag) + RND) >> SH_R) << SH_L;
        if (!r_f1_sgn) begin
            n_out = (w_mr >= MAG_LIM) ? {1'b0, {(nica_pkg::OUT_W-1){1'b1}}}
                                      : w_mr[nica_pkg::OUT_W-1:0];
        end else begin
            n_out = (w_mr >= MAG_LIM) ? {1'b1, {(nica_pkg::OUT_W-1){1'b0}}}
                                      : nica_pkg::OUT_W'(-w_mr[nica_pkg::OUT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out <= n_out;
        end
    end

    assign o_out.normal_value = r_out;

    // an accepted item is tracked in the first stage
    `NICA_ASSERT_NEXT(a_accept_tracked, i_in.valid && i_in.ready, r_vld[0])
    // a held pipe keeps every valid bit in place
    `NICA_ASSERT_NEXT(a_hold_stable, !w_ce, $stable(r_vld))
    // an occupied output stage gates input acceptance on the sink
    `NICA_ASSERT_IMPL(a_ready_link, r_vld[NST-1], i_in.ready == o_out.ready)

endmodule

FILE: sim/normal_inverse_cdf_approx_tb.sv
// testbench for the inverse normal cdf block: scoreboard against a fixed-point predictor
`timescale 1ns / 100ps

module normal_inverse_cdf_approx_tb;

    localparam int FRAC_BITS  = 16;
    localparam int LATENCY    = 87;
    localparam int STALL_MAX  = 20000;

    typedef logic signed [nica_pkg::OUT_W-1:0] t_deviate;

    // expected deviates, oldest first
    class deviate_scoreboard;
        t_deviate pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // integer square root, floor
        static function automatic logic [63:0] floor_sqrt(logic [63:0] n);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // -log2(p) in Q28 for p in Q0.32
        static function automatic logic [63:0] minus_log2(logic [63:0] p);
            int          lead;
            logic [63:0] mant;
            logic [63:0] frac;
            lead = 31;
            frac = 0;
            while (lead > 0 && p[lead] == 1'b0) lead--;
            if (lead >= 30) mant = p >> (lead - 30);
            else            mant = p << (30 - lead);
            for (int i = 0; i < 28; i++) begin
                mant = (mant * mant) >> 30;
                if (mant >= (64'd1 << 31)) begin
                    mant = mant >> 1;
                    frac[27-i] = 1'b1;
                end
            end
            return (64'(32 - lead) << 28) - frac;
        endfunction

        static function automatic t_deviate inverse_cdf(logic [nica_pkg::IN_W-1:0] x);
            logic        lower;
            logic [63:0] p, lq, arg, t, a, den, b, num, q, mag;
            logic [127:0] wide;
            logic signed [63:0] v, r;
            lower = x < (24'd1 << 23);
            p = lower ? (64'(x) << 8) : ((64'd1 << 24) - 64'(x)) << 8;
            if (p < 64'(nica_pkg::P_MIN)) p = 64'(nica_pkg::P_MIN);
            lq   = minus_log2(p);
            wide = 128'(lq) * 128'(nica_pkg::TWO_LN2_Q30);
            arg  = 64'(wide >> 30);
            t    = floor_sqrt(arg << 12);
            a    = nica_pkg::C_D3 * t + (nica_pkg::C_D2 << 20);
            a    = ((a * t) >> 20) + (nica_pkg::C_D1 << 20);
            den  = ((a * t) >> 20) + (nica_pkg::C_D0 << 20);
            b    = nica_pkg::C_N2 * t + (nica_pkg::C_N1 << 20);
            num  = ((b * t) >> 20) + (nica_pkg::C_N0 << 20);
            q    = 64'((128'(num) << 20) / 128'(den));
            v    = $signed(t) - $signed(q);
            if (lower) v = -v;
            mag = (v < 0) ? 64'(-v) : 64'(v);
            if (FRAC_BITS < 20)
                mag = (mag + (64'd1 << (19 - FRAC_BITS))) >> (20 - FRAC_BITS);
            else
                mag = mag << (FRAC_BITS - 20);
            if (mag > 64'd524288) mag = 64'd524288;
            r = (v < 0) ? -$signed(mag) : $signed(mag);
            if (r > 524287)  r = 524287;
            if (r < -524288) r = -524288;
            return r[nica_pkg::OUT_W-1:0];
        endfunction

        function void note_fraction(logic [nica_pkg::IN_W-1:0] x);
            pending.push_back(inverse_cdf(x));
        endfunction

        task check_deviate(t_deviate got);
            t_deviate want;
            if (pending.size() == 0) begin
                report_mismatch("deviate with nothing pending", got, 0);
                return;
            end
            want = pending.pop_front();
            if (got !== want) report_mismatch("normal_value", got, want);
        endtask

        task report_mismatch(string what, t_deviate got, t_deviate want);
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    nica_in_if  in_ch ();
    nica_out_if out_ch ();

    normal_inverse_cdf_approx #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    deviate_scoreboard scoreboard;
    int send_idle_pct;
    int take_idle_pct;
    int quiet_cycles;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        scoreboard           = new();
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.uniform_fraction = '0;
        out_ch.ready         = 1'b0;
        send_idle_pct        = 9;
        take_idle_pct        = 63;
    end

    // sink side: random stalls, check every accepted deviate
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            scoreboard.check_deviate(out_ch.normal_value);
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= take_idle_pct);
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("normal_inverse_cdf_approx_tb failed");
            $finish;
        end
    end
    initial quiet_cycles = 0;

    // present one fraction, hold it until taken; idle first at random
    task automatic send_fraction(logic [nica_pkg::IN_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.uniform_fraction <= x;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        scoreboard.note_fraction(x);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.pending.size() != 0) @(posedge i_clk);
    endtask

    // fractions: mostly uniform, some near the tails and near one half
    function automatic logic [nica_pkg::IN_W-1:0] pick_fraction();
        case ($urandom_range(9))
            0: return 24'($urandom_range(8191));
            1: return 24'(24'hFFFFFF - $urandom_range(8191));
            2: return 24'(24'h800000 + $urandom_range(4095) - 2048);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [nica_pkg::IN_W-1:0] directed [$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, clamp edges, exactly one half and its neighbors
        directed = '{24'h000000, 24'h000001, 24'h000010, 24'h000011, 24'h0000FF,
                     24'h7FFFFF, 24'h800000, 24'h800001, 24'h7FFFFE, 24'h400000,
                     24'hC00000, 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFF0, 24'hFFFFEF,
                     24'h555555, 24'hAAAAAA, 24'h123456, 24'hEDCBA9, 24'h0F0F0F};
        foreach (directed[i]) send_fraction(directed[i]);

        // hold off until every expected deviate is back
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 63 : 0;
            take_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 9 : 0;
            repeat (210) send_fraction(pick_fraction());
            if (phase == 0) wait_drained();
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.pending.size() == 0)
            $display("normal_inverse_cdf_approx_tb passed");
        else
            $display("normal_inverse_cdf_approx_tb failed");
        $finish;
    end
endmodule
